/* src/assert_macros.svh */
// Assertion macros shared by the mode selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DBMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DBMS_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define DBMS_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define DBMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBMS_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg)
`define DBMS_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

/* src/dbms_pkg.sv */
// Types and constants of the dual button mode selector.
`timescale 1ns / 1ps
package dbms_pkg;

	typedef logic [3:0] mode_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int IN_TDATA_BITS  = 40;
	localparam int OUT_TDATA_BITS = 16;
	localparam int NOW_BITS       = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_DUAL_HOLD   = 3'd1,
		REG_IDLE        = 3'd2,
		REG_MODE_COUNT  = 3'd3,
		REG_LEFT_START  = 3'd4,
		REG_RIGHT_START = 3'd5
	} reg_index_t;

	localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
	localparam logic [15:0] DUAL_HOLD_RST   = 16'd1000;
	localparam logic [15:0] IDLE_RST        = 16'd5000;
	localparam logic [4:0]  MODE_COUNT_RST  = 5'd4;
	localparam mode_t       START_MODE_RST  = 4'd0;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] dual_hold_ms;
		logic [15:0] idle_timeout_ms;
		logic [4:0]  mode_count;
		mode_t       left_start_mode;
		mode_t       right_start_mode;
	} cfg_t;

	typedef struct packed {
		logic load_left;
		logic load_right;
	} mode_load_t;

	typedef struct packed {
		logic advance;
		logic enable;
		logic force_block;
		logic load;
	} btn_ctl_t;

	typedef struct packed {
		logic  select_active;
		logic  both_held;
		mode_t left_mode_out;
		mode_t right_mode_out;
		logic  left_screen_press;
		logic  right_screen_press;
		logic  save_modes;
	} result_t;

	typedef struct packed {
		logic select_q;
		logic toggle;
	} core_status_t;

endpackage

/* src/dbms_cfg.sv */
// Configuration register file of the mode selector.
`timescale 1ns / 1ps
module dbms_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dbms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dbms_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output dbms_pkg::cfg_t                        cfg,
	output dbms_pkg::mode_load_t                  mode_load
);

	dbms_pkg::cfg_t       cfg_q;
	dbms_pkg::mode_load_t mode_load_q;
	logic                 wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;
	assign mode_load = mode_load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= dbms_pkg::DEBOUNCE_RST;
			cfg_q.dual_hold_ms     <= dbms_pkg::DUAL_HOLD_RST;
			cfg_q.idle_timeout_ms  <= dbms_pkg::IDLE_RST;
			cfg_q.mode_count       <= dbms_pkg::MODE_COUNT_RST;
			cfg_q.left_start_mode  <= dbms_pkg::START_MODE_RST;
			cfg_q.right_start_mode <= dbms_pkg::START_MODE_RST;
		end else if (wr) begin
			// indexes past the list are dropped
			unique case (cfg_index)
				dbms_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms      <= cfg_data;
				dbms_pkg::REG_DUAL_HOLD:   cfg_q.dual_hold_ms     <= cfg_data;
				dbms_pkg::REG_IDLE:        cfg_q.idle_timeout_ms  <= cfg_data;
				dbms_pkg::REG_MODE_COUNT:  cfg_q.mode_count       <= cfg_data[4:0];
				dbms_pkg::REG_LEFT_START:  cfg_q.left_start_mode  <= cfg_data[3:0];
				dbms_pkg::REG_RIGHT_START: cfg_q.right_start_mode <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// load the current mode through a registered strobe after the write, once the register holds the new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_load_q <= '0;
		end else begin
			mode_load_q.load_left  <= wr && (cfg_index == dbms_pkg::REG_LEFT_START);
			mode_load_q.load_right <= wr && (cfg_index == dbms_pkg::REG_RIGHT_START);
		end
	end

endmodule

/* src/dbms_button.sv */
// Per-button debounce and mode stepping with its own state registers.
`timescale 1ns / 1ps
module dbms_button #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dbms_pkg::btn_ctl_t   ctl,
	input  logic                 level,
	input  logic [TIME_BITS-1:0] now,
	input  logic [15:0]          debounce_ms,
	input  logic [4:0]           mode_count,
	input  dbms_pkg::mode_t      load_value,
	output dbms_pkg::mode_t      mode_next
);

	logic                 prev_q, blocked_q;
	logic [TIME_BITS-1:0] edge_time_q;
	dbms_pkg::mode_t      mode_q;

	logic                 prev_d, blocked_d;
	logic [TIME_BITS-1:0] edge_time_d;
	logic [TIME_BITS-1:0] held;
	logic [4:0]           mode_inc;
	dbms_pkg::mode_t      mode_d;

	always_comb begin
		prev_d      = prev_q;
		edge_time_d = edge_time_q;
		blocked_d   = ctl.force_block ? 1'b1 : blocked_q;
		mode_d      = mode_q;
		mode_inc    = {1'b0, mode_q} + 5'd1;
		if (mode_inc >= mode_count) begin
			mode_inc = 5'd0;
		end
		held = now - edge_time_q;
		if (ctl.enable) begin
			if (prev_q != level) begin
				edge_time_d = now;
				prev_d      = level;
				if (!level) begin
					blocked_d = 1'b0;
				end
			end
			held = now - edge_time_d;
			if (level && !blocked_d && (held > TIME_BITS'(debounce_ms))) begin
				blocked_d = 1'b1;
				mode_d    = mode_inc[3:0];
			end
		end
	end

	assign mode_next = mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			blocked_q   <= 1'b0;
			edge_time_q <= '0;
			mode_q      <= dbms_pkg::START_MODE_RST;
		end else if (ctl.load) begin
			mode_q <= load_value;
		end else if (ctl.advance) begin
			prev_q      <= prev_d;
			blocked_q   <= blocked_d;
			edge_time_q <= edge_time_d;
			mode_q      <= mode_d;
		end
	end

endmodule

/* src/dbms_core.sv */
// Dual-hold toggle, idle timeout and result logic of the mode selector.
`timescale 1ns / 1ps
module dbms_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   left_pressed,
	input  logic                   right_pressed,
	input  logic [TIME_BITS-1:0]   now,
	input  dbms_pkg::cfg_t         cfg,
	input  dbms_pkg::mode_load_t   mode_load,
	output dbms_pkg::result_t      result,
	output dbms_pkg::core_status_t status
);

	logic                 select_q, dual_q, latch_q;
	logic [TIME_BITS-1:0] dual_start_q, last_press_q;

	logic                 select_d, dual_d, latch_d;
	logic [TIME_BITS-1:0] dual_start_d, last_press_d;
	logic [TIME_BITS-1:0] dual_elapsed, idle_elapsed;
	logic                 both, skip_idle, toggle_dual, toggle_idle, toggle;
	dbms_pkg::btn_ctl_t   left_ctl, right_ctl;
	dbms_pkg::mode_t      left_mode, right_mode;

	always_comb begin
		both         = left_pressed && right_pressed;
		last_press_d = (left_pressed || right_pressed) ? now : last_press_q;
		dual_d       = dual_q;
		dual_start_d = dual_start_q;
		latch_d      = latch_q;
		skip_idle    = 1'b0;
		toggle_dual  = 1'b0;
		dual_elapsed = now - dual_start_q;
		if (both) begin
			if (!dual_q) begin
				dual_d       = 1'b1;
				dual_start_d = now;
			end else begin
				toggle_dual = !latch_q && (dual_elapsed >= TIME_BITS'(cfg.dual_hold_ms));
				skip_idle   = 1'b1;
			end
		end else begin
			dual_d  = 1'b0;
			latch_d = 1'b0;
		end
		// idle check sees the press time of this sample
		idle_elapsed = now - last_press_d;
		toggle_idle  = !skip_idle && select_q &&
			(idle_elapsed > TIME_BITS'(cfg.idle_timeout_ms));
		toggle   = toggle_dual || toggle_idle;
		select_d = select_q ^ toggle;
		if (toggle) begin
			latch_d = 1'b1;
		end
	end

	assign left_ctl.advance      = advance;
	assign left_ctl.enable       = select_d;
	assign left_ctl.force_block  = toggle && select_d;
	assign left_ctl.load         = mode_load.load_left;
	assign right_ctl.advance     = advance;
	assign right_ctl.enable      = select_d;
	assign right_ctl.force_block = toggle && select_d;
	assign right_ctl.load        = mode_load.load_right;

	dbms_button #(.TIME_BITS(TIME_BITS)) u_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (left_ctl),
		.level       (left_pressed),
		.now         (now),
		.debounce_ms (cfg.debounce_ms),
		.mode_count  (cfg.mode_count),
		.load_value  (cfg.left_start_mode),
		.mode_next   (left_mode)
	);

	dbms_button #(.TIME_BITS(TIME_BITS)) u_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (right_ctl),
		.level       (right_pressed),
		.now         (now),
		.debounce_ms (cfg.debounce_ms),
		.mode_count  (cfg.mode_count),
		.load_value  (cfg.right_start_mode),
		.mode_next   (right_mode)
	);

	assign result.select_active      = select_d;
	assign result.both_held          = dual_d;
	assign result.left_mode_out      = left_mode;
	assign result.right_mode_out     = right_mode;
	assign result.left_screen_press  = left_pressed && !select_d && !dual_d;
	assign result.right_screen_press = right_pressed && !select_d && !dual_d;
	assign result.save_modes         = toggle && !select_d;

	assign status.select_q = select_q;
	assign status.toggle   = toggle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q     <= 1'b0;
			dual_q       <= 1'b0;
			latch_q      <= 1'b0;
			dual_start_q <= '0;
			last_press_q <= '0;
		end else if (advance) begin
			select_q     <= select_d;
			dual_q       <= dual_d;
			latch_q      <= latch_d;
			dual_start_q <= dual_start_d;
			last_press_q <= last_press_d;
		end
	end

endmodule

/* src/dual_button_mode_selector_unit.sv */
// Top level of the dual button mode selector.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one button sample per transfer and returns exactly one result per
// sample. A sample enters an input register, then one combinational pass
// through the toggle, timeout and debounce logic updates the state and
// loads the result register: one sample per cycle sustained while each result
// is taken. The result register frees the input side, so a new sample is
// taken while a result waits, and the block stalls only when both registers
// are full and the result is not taken. Timestamps are compared as wrapping
// differences of TIME_BITS bits (now_ms is truncated or zero-extended).
// Writing a start mode also loads it as the current mode in the cycle after
// the write. Configure only while no sample is in flight.
module dual_button_mode_selector_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// left_pressed[0], right_pressed[1], now_ms[33:2], zero[39:34]
	input  logic [dbms_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// select_active[0], both_held[1], left_mode_out[5:2], right_mode_out[9:6],
	// left_screen_press[10], right_screen_press[11], save_modes[12], zero[15:13]
	output logic [dbms_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dbms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dbms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	dbms_pkg::cfg_t         cfg;
	dbms_pkg::mode_load_t   mode_load;
	dbms_pkg::result_t      result;
	dbms_pkg::core_status_t status;

	logic                 valid_s1;
	logic                 left_s1, right_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic [63:0]          now_wide;
	logic                 out_valid_q;
	dbms_pkg::result_t    out_q;
	logic                 advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign now_wide      = {32'd0, s_axis_tdata[dbms_pkg::NOW_BITS+1:2]};

	dbms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.mode_load (mode_load)
	);

	dbms_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.left_pressed  (left_s1),
		.right_pressed (right_s1),
		.now           (now_s1),
		.cfg           (cfg),
		.mode_load     (mode_load),
		.result        (result),
		.status        (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			left_s1  <= s_axis_tdata[0];
			right_s1 <= s_axis_tdata[1];
			now_s1   <= now_wide[TIME_BITS-1:0];
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.save_modes, out_q.right_screen_press,
		out_q.left_screen_press, out_q.right_mode_out, out_q.left_mode_out,
		out_q.both_held, out_q.select_active};

	`DBMS_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, !s_axis_tready, valid_s1 && out_valid_q && !m_axis_tready, "input stalled without a full pipeline")
	`DBMS_ASSERT_IMPLY(a_save_from_select, clk, arst_n, advance && result.save_modes, status.select_q, "save strobe without an active select mode")
	`DBMS_ASSERT_NEXT(a_toggle_flips_select, clk, arst_n, advance && status.toggle, m_axis_tdata[0] != $past(status.select_q), "toggle did not flip select mode")
	`DBMS_ASSERT(a_screen_press_masked, clk, arst_n, !(m_axis_tvalid && m_axis_tdata[0] && (m_axis_tdata[10] || m_axis_tdata[11])), "screen press shown in select mode")

endmodule
